>>> sv/dual_free_list_allocator_core_assert.svh
// Assertion macros for the dual free-list allocator core
`ifndef DUAL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define DUAL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define DFLA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DFLA_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DFLA_ASSERT(label, prop, msg)
`define DFLA_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> sv/dfla_pkg.sv
// Shared types and constants of the dual free-list allocator
`timescale 1ns / 1ps

package dfla_pkg;

	localparam int DEF_POOL_ENTRIES = 1024;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_EMPTY = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'b001,
		ST_IDLE  = 3'b010,
		ST_BUSY  = 3'b100
	} state_t;

endpackage

>>> sv/dfla_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module dfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/dual_free_list_allocator_core.sv
// Dual linked free-list allocator: top level with link RAM, pool heads and counts
//
// Two independent LIFO pools of POOL_ENTRIES entries each. A command (allocate or release)
// is taken when in_ready is high and its result is loaded into the output register when
// the block is busy and the output is free; the next command is taken only after that, and
// the pool head moves only once the registered read of the shared link RAM has returned.
// A new command is taken while the previous result still waits on the output; the block
// stalls only if that result is still unclaimed when the next one is ready. After reset
// the link RAM is initialised by a sweep that chains the entries of each pool in order,
// during which in_ready stays low.
`timescale 1ns / 1ps
`include "dual_free_list_allocator_core_assert.svh"

module dual_free_list_allocator_core #(
	parameter int POOL_ENTRIES = dfla_pkg::DEF_POOL_ENTRIES,
	localparam int IDX_W = $clog2(POOL_ENTRIES),
	localparam int CNT_W = $clog2(POOL_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic             pool_select,
	input  logic [IDX_W-1:0] release_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] granted_index,
	output logic             status,
	output logic [CNT_W-1:0] free_count
);

	import dfla_pkg::*;

	localparam int ADDR_W = IDX_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;
	localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(POOL_ENTRIES);
	localparam logic [IDX_W:0] NULL_WIDE = (IDX_W + 1)'(POOL_ENTRIES);

	state_t            state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [CNT_W-1:0]  spd_head_q;
	logic [CNT_W-1:0]  fix_head_q;
	logic [CNT_W-1:0]  spd_free_q;
	logic [CNT_W-1:0]  fix_free_q;

	cmd_t              cmd_s1;
	logic              pool_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              out_valid_q;
	logic [IDX_W-1:0]  granted_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;

	logic              accept;
	logic              out_free;
	logic              finish;
	logic [CNT_W-1:0]  sel_head;
	logic              rel_ok;
	logic [IDX_W:0]    sweep_nxt;
	logic [CNT_W-1:0]  sweep_link;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CNT_W-1:0]  rd_link;

	logic [CNT_W-1:0]  cur_head;
	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  new_head;
	logic [CNT_W-1:0]  new_cnt;
	logic [IDX_W-1:0]  res_grant;
	status_t           res_status;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_BUSY) && out_free;

	assign sel_head = pool_select ? fix_head_q : spd_head_q;
	assign rel_ok   = CNT_W'(release_index) < NULL_LINK;

	assign sweep_nxt  = {1'b0, sweep_q[IDX_W-1:0]} + (IDX_W + 1)'(1);
	assign sweep_link = (sweep_nxt < NULL_WIDE) ? CNT_W'(sweep_nxt) : NULL_LINK;

	always_comb begin
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = sweep_link;
		end else begin
			ram_we    = accept && (cmd_t'(cmd) == CMD_RELEASE) && rel_ok;
			ram_waddr = {pool_select, release_index};
			ram_wdata = sel_head;
		end
	end

	assign ram_re    = accept && (cmd_t'(cmd) == CMD_ALLOC);
	assign ram_raddr = {pool_select, sel_head[IDX_W-1:0]};

	dfla_ram #(
		.WIDTH (CNT_W),
		.DEPTH (RAM_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_link)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			pool_s1 <= pool_select;
			idx_s1  <= release_index;
		end
	end

	assign cur_head = pool_s1 ? fix_head_q : spd_head_q;
	assign cur_cnt  = pool_s1 ? fix_free_q : spd_free_q;

	always_comb begin
		new_head   = cur_head;
		new_cnt    = cur_cnt;
		res_grant  = '0;
		res_status = STATUS_OK;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (cur_head >= NULL_LINK) begin
					res_status = STATUS_EMPTY;
				end else begin
					res_grant = cur_head[IDX_W-1:0];
					new_head  = (rd_link < NULL_LINK) ? rd_link : NULL_LINK;
					if (cur_cnt != '0) begin
						new_cnt = cur_cnt - CNT_W'(1);
					end
				end
			end
			CMD_RELEASE: begin
				if (CNT_W'(idx_s1) < NULL_LINK) begin
					new_head = CNT_W'(idx_s1);
					if (cur_cnt < NULL_LINK) begin
						new_cnt = cur_cnt + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_head_q <= '0;
			fix_head_q <= '0;
			spd_free_q <= NULL_LINK;
			fix_free_q <= NULL_LINK;
		end else if (finish) begin
			if (pool_s1) begin
				fix_head_q <= new_head;
				fix_free_q <= new_cnt;
			end else begin
				spd_head_q <= new_head;
				spd_free_q <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the transfer completes
	always_ff @(posedge clk) begin
		if (finish) begin
			granted_q <= res_grant;
			status_q  <= res_status;
			count_q   <= new_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign free_count    = count_q;

	`DFLA_ASSERT(a_head_range, (spd_head_q <= NULL_LINK) && (fix_head_q <= NULL_LINK), "pool head beyond null link")
	`DFLA_ASSERT(a_count_range, (spd_free_q <= NULL_LINK) && (fix_free_q <= NULL_LINK), "free count above pool size")
	`DFLA_ASSERT(a_accept_to_busy, in_valid && in_ready |=> state_q == ST_BUSY, "accepted command not in progress")
	`DFLA_ASSERT(a_out_from_busy, $rose(out_valid_q) |-> $past(state_q == ST_BUSY), "result raised outside busy state")
	`DFLA_ASSERT_NEVER(a_empty_grant, out_valid_q && (status_q == STATUS_EMPTY) && (granted_q != '0), "empty pool reported with a granted entry")

endmodule
